@@ rtl/psa_pkg.sv @@
// Shared types, codes and constants of the priority scheduler with aging.
// Depends on nothing; every other file of the block uses it.
`default_nettype none

package psa_pkg;

  localparam int DEFAULT_QUEUE_DEPTH = 16;

  localparam int ID_W     = 8;
  localparam int SPRIO_W  = 8;
  localparam int PRIO_W   = 16;
  localparam int SLICE_W  = 8;
  localparam int COUNT_W  = 9;
  localparam int STATUS_W = 2;

  localparam logic signed [PRIO_W-1:0] PRIO_MIN = {1'b1, {(PRIO_W-1){1'b0}}};

  // opcodes
  localparam logic OP_ADD      = 1'b0;
  localparam logic OP_DISPATCH = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] STAT_ADDED      = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_REJECTED   = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_DISPATCHED = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_EMPTY      = 2'd3;

  // configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = CFG_ADDR_W - 2;
  localparam logic [CFG_IDX_W-1:0] REG_FINISH_THRESHOLD = 1'd0;

  typedef struct packed {
    logic [ID_W-1:0]           id;
    logic signed [PRIO_W-1:0]  prio;
    logic [SLICE_W-1:0]        need;
    logic [SLICE_W-1:0]        used;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HEAD_EVAL,
    ST_INS_RD,
    ST_INS_CMP,
    ST_INS_PUT,
    ST_RESULT
  } state_t;

endpackage

`default_nettype wire

@@ rtl/psa_channels.sv @@
// Valid/ready channel interfaces for the scheduler's item and result words.
// Depends on psa_pkg for field widths.
`default_nettype none

interface psa_in_if;
  logic                              valid;
  logic                              ready;
  logic                              opcode;
  logic [psa_pkg::ID_W-1:0]          proc_id;
  logic signed [psa_pkg::SPRIO_W-1:0] start_priority;
  logic [psa_pkg::SLICE_W-1:0]       need_slices;

  modport source (output valid, output opcode, output proc_id, output start_priority,
                  output need_slices, input ready);
  modport sink   (input valid, input opcode, input proc_id, input start_priority,
                  input need_slices, output ready);
endinterface

interface psa_out_if;
  logic                              valid;
  logic                              ready;
  logic [psa_pkg::STATUS_W-1:0]      status;
  logic [psa_pkg::ID_W-1:0]          run_id;
  logic [psa_pkg::SLICE_W-1:0]       slices_run;
  logic                              finished;
  logic [psa_pkg::COUNT_W-1:0]       queue_count;

  modport source (output valid, output status, output run_id, output slices_run,
                  output finished, output queue_count, input ready);
  modport sink   (input valid, input status, input run_id, input slices_run,
                  input finished, input queue_count, output ready);
endinterface

`default_nettype wire

@@ rtl/psa_entry_ram.sv @@
// Entry memory of the ready queue: one write port, one read port, registered read.
// Depends on psa_pkg for the entry type.
`default_nettype none

module psa_entry_ram #(
  parameter int DEPTH = psa_pkg::DEFAULT_QUEUE_DEPTH,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic            clk,
  input  wire logic            we,
  input  wire logic [AW-1:0]   waddr,
  input  wire psa_pkg::entry_t wdata,
  input  wire logic [AW-1:0]   raddr,
  output psa_pkg::entry_t      rdata
);

  psa_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ rtl/priority_scheduler_with_aging.sv @@
// Add: read the tail (ST_INS_RD), walk up in ST_INS_CMP moving lower-priority entries,
// ST_INS_PUT if the walk passes the head; an empty queue takes it directly, a full one
// rejects it. Dispatch evaluates the head in ST_HEAD_EVAL and inserts a requeued one
// like an add. One word at a time: a new word is taken only in ST_IDLE.
// Reset (rst_n low, synchronous): queue count, head pointer, state, output valid
// and finish_threshold clear; the entry memory is not cleared and needs no sweep.
`default_nettype none

module priority_scheduler_with_aging #(
  parameter int QUEUE_DEPTH = psa_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  psa_in_if.sink                                 in_ch,
  psa_out_if.source                              out_ch,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [psa_pkg::CFG_ADDR_W-1:0]    paddr,
  input  wire logic [psa_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic      [psa_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                                   pready
);

  // PW indexes the entry memory; CW holds a count of 0..QUEUE_DEPTH.
  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PW:0]   DEPTH_P = (PW+1)'(QUEUE_DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

  // ---------------------------------------------------------------------------
  // Configuration register
  // ---------------------------------------------------------------------------
  logic [psa_pkg::SLICE_W-1:0] thresh_r;
  logic                        cfg_wr;
  logic                        cfg_hit;

  assign pready  = 1'b1;
  assign cfg_hit = (paddr[psa_pkg::CFG_ADDR_W-1:2] == psa_pkg::REG_FINISH_THRESHOLD);
  assign cfg_wr  = psel && penable && pwrite && pready && cfg_hit;
  assign prdata  = cfg_hit ? psa_pkg::CFG_DATA_W'(thresh_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= '0;
    end else if (cfg_wr) begin
      thresh_r <= pwdata[psa_pkg::SLICE_W-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Queue state: the entries sit in a ring inside the entry memory. head_r
  // points at the highest-priority entry; logical index l lives at
  // head_r + l (mod QUEUE_DEPTH). Dispatch advances head_r and may reinsert the aged
  // head; insertion walks from the tail toward the head, moving each lower-priority
  // entry up one slot, until it meets an entry of equal or higher priority.
  // ---------------------------------------------------------------------------
  psa_pkg::state_t state_r, state_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [PW-1:0]   head_r, head_nxt;
  logic [PW-1:0]   k_r, k_nxt;           // logical index under compare
  psa_pkg::entry_t work_r, work_nxt;     // entry being inserted

  // result staging
  logic [psa_pkg::STATUS_W-1:0] res_status_r, res_status_nxt;
  logic [psa_pkg::ID_W-1:0]     res_id_r, res_id_nxt;
  logic [psa_pkg::SLICE_W-1:0]  res_slices_r, res_slices_nxt;
  logic                         res_fin_r, res_fin_nxt;

  // output register
  logic                         out_valid_r, out_valid_nxt;
  logic [psa_pkg::STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [psa_pkg::ID_W-1:0]     out_id_r, out_id_nxt;
  logic [psa_pkg::SLICE_W-1:0]  out_slices_r, out_slices_nxt;
  logic                         out_fin_r, out_fin_nxt;
  logic [psa_pkg::COUNT_W-1:0]  out_count_r, out_count_nxt;

  // memory port
  logic            mem_we;
  logic [PW-1:0]   mem_waddr;
  psa_pkg::entry_t mem_wdata;
  logic [PW-1:0]   mem_raddr;
  psa_pkg::entry_t mem_rdata;

  psa_entry_ram #(
    .DEPTH (QUEUE_DEPTH),
    .AW    (PW)
  ) u_psa_entry_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Map a logical queue index to its memory slot.
  function automatic logic [PW-1:0] slot_of(input logic [PW-1:0] hd, input logic [PW-1:0] l);
    logic [PW:0] s;
    s = {1'b0, hd} + {1'b0, l};
    if (s >= DEPTH_P) begin
      s = s - DEPTH_P;
    end
    return s[PW-1:0];
  endfunction

  // handshake
  logic in_acc;
  logic out_load;

  assign in_ch.ready = (state_r == psa_pkg::ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_load    = (state_r == psa_pkg::ST_RESULT) && (!out_valid_r || out_ch.ready);

  // head evaluation, valid in ST_HEAD_EVAL when mem_rdata is the head entry
  logic [psa_pkg::SLICE_W-1:0] head_remain;
  logic                        head_full_run;
  logic                        head_last;
  logic                        head_reinsert;
  logic signed [psa_pkg::PRIO_W-1:0] head_prio_dec;
  logic                        shift_up;

  assign head_remain   = (mem_rdata.need > mem_rdata.used) ?
                         (mem_rdata.need - mem_rdata.used) : '0;
  assign head_full_run = (head_remain <= thresh_r);
  assign head_last     = (({1'b0, mem_rdata.used} + 9'd1) == {1'b0, mem_rdata.need});
  assign head_reinsert = !head_full_run && !head_last;
  assign head_prio_dec = (mem_rdata.prio == psa_pkg::PRIO_MIN) ? mem_rdata.prio
                                                                 : (mem_rdata.prio - 16'sd1);
  // the walk keeps going while the stored entry ranks strictly lower
  assign shift_up      = ($signed(mem_rdata.prio) < $signed(work_r.prio));

  // ---------------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      psa_pkg::ST_IDLE: begin
        if (in_acc) begin
          priority if (in_ch.opcode == psa_pkg::OP_ADD) begin
            state_nxt = (count_r == DEPTH_C) ? psa_pkg::ST_RESULT : psa_pkg::ST_INS_RD;
          end else begin
            state_nxt = (count_r == '0) ? psa_pkg::ST_RESULT : psa_pkg::ST_HEAD_EVAL;
          end
        end
      end
      psa_pkg::ST_HEAD_EVAL: begin
        state_nxt = head_reinsert ? psa_pkg::ST_INS_RD : psa_pkg::ST_RESULT;
      end
      psa_pkg::ST_INS_RD: begin
        state_nxt = (count_r == '0) ? psa_pkg::ST_RESULT : psa_pkg::ST_INS_CMP;
      end
      psa_pkg::ST_INS_CMP: begin
        priority if (!shift_up) begin
          state_nxt = psa_pkg::ST_RESULT;
        end else if (k_r == '0) begin
          state_nxt = psa_pkg::ST_INS_PUT;
        end else begin
          state_nxt = psa_pkg::ST_INS_CMP;
        end
      end
      psa_pkg::ST_INS_PUT: begin
        state_nxt = psa_pkg::ST_RESULT;
      end
      psa_pkg::ST_RESULT: begin
        if (out_load) begin
          state_nxt = psa_pkg::ST_IDLE;
        end
      end
      default: state_nxt = psa_pkg::ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Datapath and memory control
  // ---------------------------------------------------------------------------
  always_comb begin
    count_nxt      = count_r;
    head_nxt       = head_r;
    k_nxt          = k_r;
    work_nxt       = work_r;
    res_status_nxt = res_status_r;
    res_id_nxt     = res_id_r;
    res_slices_nxt = res_slices_r;
    res_fin_nxt    = res_fin_r;
    mem_we         = 1'b0;
    mem_waddr      = slot_of(head_r, k_r + 1'b1);
    mem_wdata      = mem_rdata;
    mem_raddr      = head_r;

    unique case (state_r)
      psa_pkg::ST_IDLE: begin
        if (in_acc) begin
          res_id_nxt     = '0;
          res_slices_nxt = '0;
          res_fin_nxt    = 1'b0;
          work_nxt.id    = in_ch.proc_id;
          work_nxt.prio  = {{(psa_pkg::PRIO_W-psa_pkg::SPRIO_W){in_ch.start_priority[7]}},
                            in_ch.start_priority};
          work_nxt.need  = in_ch.need_slices;
          work_nxt.used  = '0;
          priority if (in_ch.opcode == psa_pkg::OP_ADD) begin
            res_status_nxt = (count_r == DEPTH_C) ? psa_pkg::STAT_REJECTED
                                                  : psa_pkg::STAT_ADDED;
          end else begin
            // head read issued here: mem_raddr defaults to head_r
            res_status_nxt = (count_r == '0) ? psa_pkg::STAT_EMPTY
                                             : psa_pkg::STAT_DISPATCHED;
          end
        end
      end
      psa_pkg::ST_HEAD_EVAL: begin
        // drop the head from the ring
        head_nxt       = slot_of(head_r, PW'(1));
        count_nxt      = count_r - 1'b1;
        res_id_nxt     = mem_rdata.id;
        res_slices_nxt = head_full_run ? head_remain : 8'd1;
        res_fin_nxt    = !head_reinsert;
        work_nxt.id    = mem_rdata.id;
        work_nxt.prio  = head_prio_dec;
        work_nxt.need  = mem_rdata.need;
        work_nxt.used  = mem_rdata.used + 1'b1;
      end
      psa_pkg::ST_INS_RD: begin
        if (count_r == '0) begin
          mem_we    = 1'b1;
          mem_waddr = head_r;
          mem_wdata = work_r;
          count_nxt = count_r + 1'b1;
        end else begin
          // start the walk at the tail
          k_nxt     = PW'(count_r - 1'b1);
          mem_raddr = slot_of(head_r, PW'(count_r - 1'b1));
        end
      end
      psa_pkg::ST_INS_CMP: begin
        mem_we    = 1'b1;
        mem_waddr = slot_of(head_r, k_r + 1'b1);
        if (shift_up) begin
          // move this entry up; read the next one toward the head
          mem_wdata = mem_rdata;
          k_nxt     = k_r - 1'b1;
          mem_raddr = slot_of(head_r, k_r - 1'b1);
        end else begin
          mem_wdata = work_r;
          count_nxt = count_r + 1'b1;
        end
      end
      psa_pkg::ST_INS_PUT: begin
        mem_we    = 1'b1;
        mem_waddr = head_r;
        mem_wdata = work_r;
        count_nxt = count_r + 1'b1;
      end
      psa_pkg::ST_RESULT: begin
        // hold until the output register frees up
      end
      default: begin
      end
    endcase
  end

  // output register: load from staging, drop on handshake
  always_comb begin
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_id_nxt     = out_id_r;
    out_slices_nxt = out_slices_r;
    out_fin_nxt    = out_fin_r;
    out_count_nxt  = out_count_r;
    if (out_load) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = res_status_r;
      out_id_nxt     = res_id_r;
      out_slices_nxt = res_slices_r;
      out_fin_nxt    = res_fin_r;
      out_count_nxt  = psa_pkg::COUNT_W'(count_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= psa_pkg::ST_IDLE;
      count_r     <= '0;
      head_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      head_r      <= head_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r          <= k_nxt;
    work_r       <= work_nxt;
    res_status_r <= res_status_nxt;
    res_id_r     <= res_id_nxt;
    res_slices_r <= res_slices_nxt;
    res_fin_r    <= res_fin_nxt;
    out_status_r <= out_status_nxt;
    out_id_r     <= out_id_nxt;
    out_slices_r <= out_slices_nxt;
    out_fin_r    <= out_fin_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.run_id      = out_id_r;
  assign out_ch.slices_run  = out_slices_r;
  assign out_ch.finished    = out_fin_r;
  assign out_ch.queue_count = out_count_r;

endmodule

`default_nettype wire

@@ rtl/psa_checker.sv @@
// Port-level checks of the scheduler's result words, bound to the top level.
// Depends on psa_pkg for status codes and widths.
`default_nettype none

module psa_checker #(
  parameter int QUEUE_DEPTH = psa_pkg::DEFAULT_QUEUE_DEPTH
) (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              out_valid,
  input wire logic                              out_ready,
  input wire logic [psa_pkg::STATUS_W-1:0]      status,
  input wire logic [psa_pkg::ID_W-1:0]          run_id,
  input wire logic [psa_pkg::SLICE_W-1:0]       slices_run,
  input wire logic                              finished,
  input wire logic [psa_pkg::COUNT_W-1:0]       queue_count
);

  localparam logic [psa_pkg::COUNT_W-1:0] DEPTH_C = psa_pkg::COUNT_W'(QUEUE_DEPTH);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(run_id)
      && $stable(slices_run) && $stable(finished) && $stable(queue_count))
    else $error("result word changed while stalled");

  a_requeue_one_slice: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status == psa_pkg::STAT_DISPATCHED) && !finished |-> slices_run == 8'd1)
    else $error("requeued process ran other than one slice");

  a_no_dispatch_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status != psa_pkg::STAT_DISPATCHED)
      |-> (run_id == '0) && (slices_run == '0) && !finished)
    else $error("dispatch fields set on a non-dispatch result");

  a_reject_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status == psa_pkg::STAT_REJECTED) |-> queue_count == DEPTH_C)
    else $error("add rejected while queue not full");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status == psa_pkg::STAT_EMPTY) |-> queue_count == '0)
    else $error("empty status with entries queued");

endmodule

bind priority_scheduler_with_aging psa_checker #(
  .QUEUE_DEPTH (QUEUE_DEPTH)
) u_psa_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .status      (out_ch.status),
  .run_id      (out_ch.run_id),
  .slices_run  (out_ch.slices_run),
  .finished    (out_ch.finished),
  .queue_count (out_ch.queue_count)
);

`default_nettype wire

@@ sim/tb_priority_scheduler_with_aging.sv @@
// Self-checking testbench for priority_scheduler_with_aging: directed and random add and
// dispatch words, checked against a predictor of the sorted ready queue and its aging rules.
// Depends on psa_pkg, psa_channels and the scheduler RTL.
module tb_priority_scheduler_with_aging;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH         = psa_pkg::DEFAULT_QUEUE_DEPTH;
  // Longest in-flight walk plus margin, waited out before the block counts as idle.
  localparam int SETTLE_CYCLES = DEPTH + 8;

  // One process in the predicted ready queue, index 0 is the head.
  typedef struct {
    logic [psa_pkg::ID_W-1:0]          id;
    logic signed [psa_pkg::PRIO_W-1:0] prio;
    logic [psa_pkg::SLICE_W-1:0]       need;
    logic [psa_pkg::SLICE_W-1:0]       used;
  } job_t;

  // One result word as the block should produce it.
  typedef struct {
    logic [psa_pkg::STATUS_W-1:0] status;
    logic [psa_pkg::ID_W-1:0]     run_id;
    logic [psa_pkg::SLICE_W-1:0]  slices_run;
    logic                         finished;
    logic [psa_pkg::COUNT_W-1:0]  queue_count;
  } sched_word_t;

  logic                           clk = 1'b0;
  logic                           rst_n;
  logic                           psel;
  logic                           penable;
  logic                           pwrite;
  logic [psa_pkg::CFG_ADDR_W-1:0] paddr;
  logic [psa_pkg::CFG_DATA_W-1:0] pwdata;
  logic [psa_pkg::CFG_DATA_W-1:0] prdata;
  logic                           pready;

  psa_in_if  in_ch ();
  psa_out_if out_ch ();

  priority_scheduler_with_aging #(.QUEUE_DEPTH(DEPTH)) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Predictor state: the ready queue, the threshold copy and the words still owed.
  job_t        ready_queue[$];
  logic [7:0]  threshold_shadow = 8'd0;
  sched_word_t expected_words[$];
  int          fail_count = 0;
  // Set to run both sides without any idling.
  bit          steady_flow = 1'b0;

  always #6 clk = ~clk;

  // Gap length: mostly none, sometimes short, rarely a long pause.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady_flow || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Insert behind every job of equal or higher priority, so ties keep arrival order.
  function automatic void enqueue_job(job_t j);
    int pos;
    pos = 0;
    while (pos < ready_queue.size() && ready_queue[pos].prio >= j.prio) pos++;
    ready_queue.insert(pos, j);
  endfunction

  // Advance the predicted queue by one accepted word and return the word it must produce.
  function automatic sched_word_t schedule_word(logic op, logic [psa_pkg::ID_W-1:0] id,
                                                logic signed [psa_pkg::SPRIO_W-1:0] sprio,
                                                logic [psa_pkg::SLICE_W-1:0] need);
    sched_word_t w;
    job_t        j;
    int          remaining;
    w.run_id     = '0;
    w.slices_run = '0;
    w.finished   = 1'b0;
    if (op == psa_pkg::OP_ADD) begin
      if (ready_queue.size() >= DEPTH) begin
        w.status = psa_pkg::STAT_REJECTED;
      end else begin
        j.id   = id;
        j.prio = sprio;  // sign-extend to the queue's priority width
        j.need = need;
        j.used = '0;
        enqueue_job(j);
        w.status = psa_pkg::STAT_ADDED;
      end
    end else if (ready_queue.size() == 0) begin
      w.status = psa_pkg::STAT_EMPTY;
    end else begin
      j = ready_queue.pop_front();
      remaining = (j.need > j.used) ? int'(j.need) - int'(j.used) : 0;
      w.status = psa_pkg::STAT_DISPATCHED;
      w.run_id = j.id;
      if (remaining == 0) begin
        // nothing left to run: done at once
        w.finished = 1'b1;
      end else if (remaining <= threshold_shadow) begin
        // short enough: run to completion
        w.slices_run = psa_pkg::SLICE_W'(remaining);
        w.finished   = 1'b1;
      end else begin
        // one slice, then age and requeue unless that was the last one
        w.slices_run = 8'd1;
        j.used = j.used + 8'd1;
        if (j.used >= j.need) begin
          w.finished = 1'b1;
        end else begin
          if (j.prio != psa_pkg::PRIO_MIN) j.prio = j.prio - 16'sd1;
          enqueue_job(j);
        end
      end
    end
    w.queue_count = psa_pkg::COUNT_W'(ready_queue.size());
    return w;
  endfunction

  // Offer one word on the input channel; predict it at the edge where it is taken.
  task automatic send_word(input logic op, input logic [psa_pkg::ID_W-1:0] id,
                           input logic signed [psa_pkg::SPRIO_W-1:0] sprio,
                           input logic [psa_pkg::SLICE_W-1:0] need);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.opcode         <= op;
    in_ch.proc_id        <= id;
    in_ch.start_priority <= sprio;
    in_ch.need_slices    <= need;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    expected_words.push_back(schedule_word(op, id, sprio, need));
  endtask

  // Drop valid and hold off until every owed word is back and the block has settled.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [15:0] exp_v,
                             input logic [15:0] act_v);
    if (act_v !== exp_v) begin
      fail_count++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
    end
  endtask

  // Write finish_threshold over the config port while idle, then read it back.
  task automatic set_threshold(input logic [7:0] value);
    logic [psa_pkg::CFG_DATA_W-1:0] readback;
    wait_idle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= psa_pkg::CFG_ADDR_W'({psa_pkg::REG_FINISH_THRESHOLD, 2'b00});
    pwdata  <= psa_pkg::CFG_DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    threshold_shadow = value;
    // read-back: setup then access, sample prdata at the access edge
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    readback = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    check_field("finish_threshold readback", 16'(value), readback[15:0]);
    if (readback[psa_pkg::CFG_DATA_W-1:16] !== '0)
      check_field("finish_threshold readback upper", 16'd0,
                  readback[psa_pkg::CFG_DATA_W-1:16]);
  endtask

  // ---------------------------------------------------------------------------
  // Directed tests
  // ---------------------------------------------------------------------------

  // Dispatch with nothing queued; the add fields carry noise and must be ignored.
  task automatic test_empty_queue();
    send_word(psa_pkg::OP_DISPATCH, 8'hFF, -8'sd1, 8'hFF);
    send_word(psa_pkg::OP_DISPATCH, 8'h00, 8'sd0, 8'h00);
  endtask

  // Field extremes, priority ties and aging with a zero threshold.
  task automatic test_field_extremes();
    send_word(psa_pkg::OP_ADD, 8'hFF, 8'sd127, 8'd255);
    send_word(psa_pkg::OP_ADD, 8'h00, -8'sd128, 8'd1);
    send_word(psa_pkg::OP_ADD, 8'h5A, -8'sd1, 8'd2);
    send_word(psa_pkg::OP_ADD, 8'hA5, 8'sd127, 8'd3);
    // head runs one slice and drops behind the equal-priority newcomer
    send_word(psa_pkg::OP_DISPATCH, 8'h00, 8'sd0, 8'd0);
    send_word(psa_pkg::OP_DISPATCH, 8'hFF, 8'sd127, 8'hFF);
    send_word(psa_pkg::OP_DISPATCH, 8'h00, -8'sd128, 8'h00);
  endtask

  // A process that needs no slices leaves on its first dispatch.
  task automatic test_zero_need();
    send_word(psa_pkg::OP_ADD, 8'h33, 8'sd127, 8'd0);
    send_word(psa_pkg::OP_DISPATCH, 8'h00, 8'sd0, 8'd0);
  endtask

  // Fill the queue, then try two adds that must bounce.
  task automatic test_full_queue();
    while (ready_queue.size() < DEPTH)
      send_word(psa_pkg::OP_ADD, 8'($urandom), 8'(int'($urandom_range(0, 6)) - 3),
                8'($urandom_range(1, 4)));
    send_word(psa_pkg::OP_ADD, 8'hC3, 8'sd127, 8'd9);
    send_word(psa_pkg::OP_ADD, 8'h3C, -8'sd128, 8'd0);
  endtask

  // With the threshold at its top every dispatch runs the head to completion.
  task automatic test_run_to_completion();
    set_threshold(8'hFF);
    repeat (3) send_word(psa_pkg::OP_DISPATCH, 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  // ---------------------------------------------------------------------------
  // Random traffic: mostly small needs and clustered priorities so that aging,
  // ties and requeues happen often; add_pct biases toward a full or empty queue.
  // ---------------------------------------------------------------------------
  task automatic test_random_traffic(input int words, input logic [7:0] thr,
                                     input int add_pct);
    logic                               op;
    logic signed [psa_pkg::SPRIO_W-1:0] sprio;
    logic [psa_pkg::SLICE_W-1:0]        need;
    int                                 r;
    set_threshold(thr);
    for (int i = 0; i < words; i++) begin
      // switch between idling and steady stretches now and then
      if (i % 40 == 0) steady_flow = ($urandom_range(0, 3) == 0);
      op = ($urandom_range(0, 99) < add_pct) ? psa_pkg::OP_ADD : psa_pkg::OP_DISPATCH;
      if ($urandom_range(0, 3) == 0) sprio = 8'($urandom);
      else sprio = 8'(int'($urandom_range(0, 4)) - 2);
      r = $urandom_range(0, 99);
      if (r < 10) need = 8'd0;
      else if (r < 80) need = 8'($urandom_range(1, 6));
      else need = 8'($urandom);
      send_word(op, 8'($urandom), sprio, need);
    end
    steady_flow = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random backpressure and the check of every taken word.
  // ---------------------------------------------------------------------------
  initial begin
    int stall;
    stall = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        stall--;
      end else begin
        out_ch.ready <= 1'b1;
        stall = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    sched_word_t w;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (expected_words.size() == 0) begin
        fail_count++;
        $display("%0t ns: unexpected result word, expected none, actual status %0d",
                 $time, out_ch.status);
      end else begin
        w = expected_words.pop_front();
        check_field("status", 16'(w.status), 16'(out_ch.status));
        check_field("run_id", 16'(w.run_id), 16'(out_ch.run_id));
        check_field("slices_run", 16'(w.slices_run), 16'(out_ch.slices_run));
        check_field("finished", 16'(w.finished), 16'(out_ch.finished));
        check_field("queue_count", 16'(w.queue_count), 16'(out_ch.queue_count));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n                <= 1'b0;
    in_ch.valid          <= 1'b0;
    in_ch.opcode         <= psa_pkg::OP_ADD;
    in_ch.proc_id        <= '0;
    in_ch.start_priority <= '0;
    in_ch.need_slices    <= '0;
    psel                 <= 1'b0;
    penable              <= 1'b0;
    pwrite               <= 1'b0;
    paddr                <= '0;
    pwdata               <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_queue();
    test_field_extremes();
    test_zero_need();
    test_full_queue();
    test_run_to_completion();

    // threshold extremes, small values and a random one; the bus drains before each
    test_random_traffic(115, 8'd0, 60);
    test_random_traffic(115, 8'hFF, 45);
    test_random_traffic(115, 8'($urandom_range(1, 8)), 55);
    test_random_traffic(115, 8'($urandom), 50);
    test_random_traffic(115, 8'd1, 70);
    test_random_traffic(40, 8'd0, 25);

    wait_idle();
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #5000000;
    $display("simulation failed");
    $finish;
  end

endmodule
